// ===== src/ols_pkg.sv =====
// ----------------------------------------------------------------------------
// ols_pkg
// Shared types and operation codes for the ordered list store.
// ----------------------------------------------------------------------------
package ols_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_SEARCH     = 3'd5,
    OP_CLEAR      = 3'd6
  } op_t;

  typedef struct packed {
    logic [2:0]                func;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic               success;
    logic [COUNT_W-1:0] count;
    logic               empty_res;
    logic               full_res;
  } out_item_t;

  // Per-cycle commands broadcast to every cell of the chain.
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic remove;
  } cell_ctl_t;

endpackage

// ===== src/ols_cell.sv =====
// ----------------------------------------------------------------------------
// ols_cell
// One list position: holds an entry, compares it against the broadcast
// value, shifts toward either neighbor on command and loads the value at the tail.
// ----------------------------------------------------------------------------
module ols_cell import ols_pkg::*; (
  input  logic                      clk,
  input  cell_ctl_t                 ctl,
  input  logic signed [VALUE_W-1:0] value,
  input  logic signed [VALUE_W-1:0] left_entry,
  input  logic signed [VALUE_W-1:0] right_entry,
  input  logic                      in_use,
  input  logic                      at_tail,
  input  logic                      match_in,
  output logic                      match_out,
  output logic signed [VALUE_W-1:0] entry
);

  logic signed [VALUE_W-1:0] entry_r;
  logic signed [VALUE_W-1:0] entry_nxt;

  // match_out is high from the first matching position onward
  assign match_out = match_in | (in_use & (entry_r == value));
  assign entry     = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.push_front) begin
      entry_nxt = left_entry;
    end else if (ctl.push_back && at_tail) begin
      entry_nxt = value;
    end else if (ctl.pop_front || (ctl.remove && match_out)) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== src/ordered_list_store.sv =====
// ----------------------------------------------------------------------------
// ordered_list_store
// Bounded ordered list of signed 32-bit values held in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries one operation per item:
//   push front/back, pop front/back, remove first equal value, search, clear.
//   Output channel out_valid/out_stall/out_data returns exactly one result
//   per item: success flag, count after the operation, empty and full.
//   The result of an accepted item is in the output register right after
//   the edge that accepts it. Throughput is one item per cycle while the
//   receiver does not stall; the whole list updates at once, every cell
//   comparing the value in parallel, a match chain rippling through cells.
//   When the receiver stalls with a result pending, in_stall rises and the
//   next item waits; the result is taken and a new item accepted in the
//   same cycle once out_stall drops.
//   Reset empties the list (count zero); entry contents are not cleared and
//   are never read before being written.
// ----------------------------------------------------------------------------
module ordered_list_store import ols_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int unsigned LEN_W = $clog2(CAPACITY + 1);

  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] len_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  out_item_t        out_data_r;
  out_item_t        out_data_nxt;

  logic                      accept;
  logic                      is_empty;
  logic                      is_full;
  logic                      found;
  logic                      success;
  cell_ctl_t                 ctl;
  logic signed [VALUE_W-1:0] ent [CAPACITY];
  logic                      match [CAPACITY+1];

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign is_empty  = (len_r == '0);
  assign is_full   = (len_r == LEN_W'(CAPACITY));
  assign match[0]  = 1'b0;
  assign found     = match[CAPACITY];

  // ---- cell chain ----
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_w;
    logic signed [VALUE_W-1:0] right_w;

    if (i == 0) begin : g_head
      assign left_w = in_data.value;
    end else begin : g_mid_l
      assign left_w = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_w = ent[i];
    end else begin : g_mid_r
      assign right_w = ent[i+1];
    end

    ols_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .value       (in_data.value),
      .left_entry  (left_w),
      .right_entry (right_w),
      .in_use      (len_r > LEN_W'(i)),
      .at_tail     (len_r == LEN_W'(i)),
      .match_in    (match[i]),
      .match_out   (match[i+1]),
      .entry       (ent[i])
    );
  end

  // ---- operation decode ----
  always_comb begin
    ctl     = '0;
    success = 1'b0;
    len_nxt = len_r;
    unique case (op_t'(in_data.func))
      OP_PUSH_FRONT: begin
        success        = ~is_full;
        ctl.push_front = accept & ~is_full;
        if (~is_full) len_nxt = len_r + LEN_W'(1);
      end
      OP_PUSH_BACK: begin
        success       = ~is_full;
        ctl.push_back = accept & ~is_full;
        if (~is_full) len_nxt = len_r + LEN_W'(1);
      end
      OP_POP_FRONT: begin
        success       = ~is_empty;
        ctl.pop_front = accept & ~is_empty;
        if (~is_empty) len_nxt = len_r - LEN_W'(1);
      end
      OP_POP_BACK: begin
        success = ~is_empty;
        if (~is_empty) len_nxt = len_r - LEN_W'(1);
      end
      OP_REMOVE: begin
        // cells shift only where the match chain is set, so a miss is a no-op
        success    = found;
        ctl.remove = accept;
        if (found) len_nxt = len_r - LEN_W'(1);
      end
      OP_SEARCH: begin
        success = found;
      end
      OP_CLEAR: begin
        success = 1'b1;
        len_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    if (accept) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.success   = success;
      out_data_nxt.count     = COUNT_W'(len_nxt);
      out_data_nxt.empty_res = (len_nxt == '0);
      out_data_nxt.full_res  = (len_nxt == LEN_W'(CAPACITY));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) len_r <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---- assertions ----
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(CAPACITY))
    else $error("list length exceeds capacity");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted item produced no result");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_full && (in_data.func == OP_PUSH_FRONT || in_data.func == OP_PUSH_BACK))
    |=> len_r == $past(len_r) + LEN_W'(1))
    else $error("successful push did not grow the list");

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_data_r.count == COUNT_W'(len_r))
    else $error("reported count differs from held length");

endmodule

// ===== bench/ordered_list_store_test.sv =====
// ----------------------------------------------------------------------------
// ordered_list_store_test
// Self-checking bench for the ordered list store. A queue-based model of the
// list predicts success, count, empty and full for every accepted item, and
// a scoreboard checks each returned result in order. Directed items hit
// empty and duplicate cases first; random items then run in fill, drain and
// mixed phases with bursty idling on both sides and one long receiver hold.
// ----------------------------------------------------------------------------
module ordered_list_store_test;
  import ols_pkg::*;

  localparam int unsigned CAPACITY     = 16;
  localparam int          RANDOM_ITEMS = 1930;
  localparam int          CYCLE_LIMIT  = 400_000;
  localparam int          HOLD_CYCLES  = 150;
  localparam logic [2:0]  OP_UNUSED    = 3'd7;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  class list_scoreboard;
    logic signed [VALUE_W-1:0] held[$];
    out_item_t                 results_due[$];
    int                        errors;

    function new();
      errors = 0;
    endfunction

    // Apply one operation to the model list and queue its result.
    function void note_input(in_item_t item);
      out_item_t res;
      int        hit;
      hit = -1;
      foreach (held[i]) begin
        if (hit < 0 && held[i] == item.value) hit = i;
      end
      res.success = 1'b0;
      case (item.func)
        OP_PUSH_FRONT: if (held.size() < CAPACITY) begin
          held.push_front(item.value);
          res.success = 1'b1;
        end
        OP_PUSH_BACK: if (held.size() < CAPACITY) begin
          held.push_back(item.value);
          res.success = 1'b1;
        end
        OP_POP_FRONT: if (held.size() > 0) begin
          void'(held.pop_front());
          res.success = 1'b1;
        end
        OP_POP_BACK: if (held.size() > 0) begin
          void'(held.pop_back());
          res.success = 1'b1;
        end
        OP_REMOVE: if (hit >= 0) begin
          held.delete(hit);
          res.success = 1'b1;
        end
        OP_SEARCH: res.success = (hit >= 0);
        OP_CLEAR: begin
          held.delete();
          res.success = 1'b1;
        end
        default: ;
      endcase
      res.count     = COUNT_W'(held.size());
      res.empty_res = (held.size() == 0);
      res.full_res  = (held.size() == CAPACITY);
      results_due.push_back(res);
    endfunction

    function void report_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %p", $time, got);
        errors++;
        return;
      end
      exp_r = results_due.pop_front();
      report_field("success", exp_r.success, got.success);
      report_field("count", exp_r.count, got.count);
      report_field("empty", exp_r.empty_res, got.empty_res);
      report_field("full", exp_r.full_res, got.full_res);
    endfunction

    function int pending();
      return results_due.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  list_scoreboard sb = new();
  bit             quiet;
  int             hold_left;
  int             cycle_count;

  ordered_list_store #(.CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Receiver: random stall bursts, plus one long hold requested by the stimulus.
  initial begin
    int burst;
    burst = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else if (!quiet && rst_n && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        burst = $urandom_range(1, 19) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input in_item_t item);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(item);
    @(negedge clk);
  endtask

  task automatic send_op(input logic [2:0] func, input logic signed [VALUE_W-1:0] value);
    in_item_t item;
    item.func  = func;
    item.value = value;
    send_item(item);
  endtask

  // Small pool of values so searches and removes hit often, plus extremes.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int unsigned r;
    logic signed [VALUE_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      v = $signed($urandom_range(0, 7)) - 4;
    end else if (r < 85) begin
      case ($urandom_range(0, 3))
        0:       v = VAL_MIN;
        1:       v = VAL_MAX;
        2:       v = '0;
        default: v = -1;
      endcase
    end else begin
      v = $urandom();
    end
    return v;
  endfunction

  function automatic logic [2:0] pick_func(mix_t mix);
    int pw;
    int dw;
    int r;
    pw = (mix == MIX_FILL) ? 30 : (mix == MIX_DRAIN) ? 8 : 17;
    dw = (mix == MIX_DRAIN) ? 20 : 8;
    r  = $urandom_range(0, 99);
    if (r < pw)               return OP_PUSH_FRONT;
    else if (r < 2*pw)        return OP_PUSH_BACK;
    else if (r < 2*pw + dw)   return OP_POP_FRONT;
    else if (r < 2*pw + 2*dw) return OP_POP_BACK;
    else if (r < 2*pw + 3*dw) return OP_REMOVE;
    else if (r < 97)          return OP_SEARCH;
    else if (r < 99)          return OP_CLEAR;
    else                      return OP_UNUSED;
  endfunction

  initial begin
    mix_t mix;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    quiet       = 1'b0;
    hold_left   = 0;
    cycle_count = 0;
    mix         = MIX_EVEN;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty-list cases
    send_op(OP_CLEAR, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_REMOVE, '0);
    send_op(OP_SEARCH, '0);
    send_op(OP_UNUSED, 32'sh5a5a_5a5a);
    // extremes and a duplicate pair
    send_op(OP_PUSH_FRONT, VAL_MIN);
    send_op(OP_PUSH_BACK, VAL_MAX);
    send_op(OP_PUSH_FRONT, -1);
    send_op(OP_PUSH_BACK, '0);
    send_op(OP_PUSH_BACK, 7);
    send_op(OP_PUSH_FRONT, 7);
    send_op(OP_SEARCH, VAL_MAX);
    send_op(OP_SEARCH, 32'sh7fff_fffe);
    send_op(OP_REMOVE, 7);        // first of the two only
    send_op(OP_REMOVE, 12345);
    send_op(OP_SEARCH, 7);
    send_op(OP_REMOVE, VAL_MIN);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_UNUSED, -1);
    send_op(OP_CLEAR, '0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) begin
        mix   = mix_t'($urandom_range(0, 2));
        quiet = ($urandom_range(0, 3) == 0);
      end
      if (n >= RANDOM_ITEMS - 200) quiet = 1'b1;
      if (n == 600) hold_left = HOLD_CYCLES;
      send_op(pick_func(mix), pick_value());
    end
    in_valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
